### rtl/wttd_pkg.sv
// ============================================================================
// wttd_pkg: shared definitions for the waypoint turn-then-drive controller
// Field widths, register codes, motion codes, CORDIC angle table.
// ============================================================================
`default_nettype none

package wttd_pkg;

    localparam int PATH_DEPTH_DEF   = 64;
    localparam int CORDIC_STEPS_DEF = 16;

    // CORDIC datapath width: 33-bit difference vector plus gain growth
    localparam int XY_W = 36;
    // Gain-compensated distance width
    localparam int DIST_W = 35;

    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [23:0] GAIN_Q24    = 24'd10188014;
    localparam logic [14:0] BAM_TO_RATE = 15'd25736;

    localparam logic [14:0] MAX_TURN_RST  = 15'd4096;
    localparam logic [30:0] MAX_SPEED_RST = 31'd32768;
    localparam logic [14:0] HEAD_TOL_RST  = 15'd521;
    localparam logic [30:0] ARRIVAL_RST   = 31'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_TURN_RATE     = 8'd0,
        REG_MAX_SPEED         = 8'd1,
        REG_HEADING_TOLERANCE = 8'd2,
        REG_ARRIVAL_RADIUS    = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MS_IDLE  = 2'd0,
        MS_TURN  = 2'd1,
        MS_DRIVE = 2'd2
    } motion_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // arctan(2^-i) in binary angle units, 2^32 = 2 pi
    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/wttd_cordic.sv
// ============================================================================
// wttd_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle; drives y toward zero, accumulates angle.
// ============================================================================
`default_nettype none

module wttd_cordic #(
    parameter int STEPS = wttd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [wttd_pkg::XY_W-1:0]  x_in,
    input  wire logic signed [wttd_pkg::XY_W-1:0]  y_in,
    input  wire logic        [31:0]                z_in,
    output wttd_pkg::cordic_stat_t                 stat,
    output logic signed      [wttd_pkg::XY_W-1:0]  x_out,
    output logic             [31:0]                z_out
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic signed [wttd_pkg::XY_W-1:0] x_reg, y_reg, x_next, y_next, sh_x, sh_y;
    logic        [31:0]               z_reg, z_next, atan_v;
    logic        [IW-1:0]             idx_reg;
    logic        [IW+4:0]             idx_ext;
    logic                             busy_reg, done_reg;

    always_comb begin
        idx_ext = {5'b0, idx_reg};
        atan_v  = wttd_pkg::atan_bam(idx_ext[4:0]);
        sh_x    = x_reg >>> idx_reg;
        sh_y    = y_reg >>> idx_reg;
        if (y_reg > 0) begin
            x_next = x_reg + sh_y;
            y_next = y_reg - sh_x;
            z_next = z_reg + atan_v;
        end else begin
            x_next = x_reg - sh_y;
            y_next = y_reg + sh_x;
            z_next = z_reg - atan_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (busy_reg) begin
                if (idx_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign z_out     = z_reg;

endmodule

`default_nettype wire

### rtl/waypoint_turn_then_drive_controller.sv
// ============================================================================
// waypoint_turn_then_drive_controller: turn-then-drive waypoint follower
// Stores a waypoint path, steers toward the current waypoint on each tick.
// ============================================================================
// Load beat: result in the output register the cycle after accept; 1 item/cycle
//   while the output is not stalled. Tick beat: S_READ, S_CORDIC (iterative vectoring
//   CORDIC), S_MUL, S_POST (waits for a free output slot); no new beat taken meanwhile.
// A tick needing no steering (idle, empty path) answers the cycle after accept.
// Reset (aresetn low, synchronous) empties the path, clears the index, goes
//   idle and restores the register defaults; table contents stay undefined.
`default_nettype none

module waypoint_turn_then_drive_controller #(
    parameter int PATH_DEPTH   = wttd_pkg::PATH_DEPTH_DEF,
    parameter int CORDIC_STEPS = wttd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: waypoint_x, waypoint_y, pose_x, pose_y, heading (lowest bit up)
    input  wire logic [wttd_pkg::S_TDATA_W-1:0]    s_tdata,
    // tuser: mode, new_path (lowest bit up)
    input  wire logic [wttd_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: speed_command, turn_command, drive_mode, current_waypoint
    output logic [wttd_pkg::M_TDATA_W-1:0]         m_tdata,
    // tuser: dropped
    output logic [0:0]                             m_tuser,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wttd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wttd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int XW = wttd_pkg::XY_W;
    localparam int DW = wttd_pkg::DIST_W;
    localparam int PW = DW + 24;   // gain product width

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_CORDIC = 5'b00100,
        S_MUL    = 5'b01000,
        S_POST   = 5'b10000
    } seq_t;

    seq_t state_reg;

    // ------------------------------------------------------------------
    // Configuration registers: always ready, unknown index is ignored
    // ------------------------------------------------------------------
    logic [14:0] max_turn_reg, head_tol_reg;
    logic [30:0] max_speed_reg, arrival_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_turn_reg  <= wttd_pkg::MAX_TURN_RST;
            max_speed_reg <= wttd_pkg::MAX_SPEED_RST;
            head_tol_reg  <= wttd_pkg::HEAD_TOL_RST;
            arrival_reg   <= wttd_pkg::ARRIVAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (wttd_pkg::cfg_reg_t'(cfg_index))
                wttd_pkg::REG_MAX_TURN_RATE:     max_turn_reg  <= cfg_data[14:0];
                wttd_pkg::REG_MAX_SPEED:         max_speed_reg <= cfg_data[30:0];
                wttd_pkg::REG_HEADING_TOLERANCE: head_tol_reg  <= cfg_data[14:0];
                wttd_pkg::REG_ARRIVAL_RADIUS:    arrival_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input beat fields
    // ------------------------------------------------------------------
    logic        in_mode, in_new_path;
    logic [31:0] in_wx, in_wy, in_px, in_py;
    logic [15:0] in_heading;

    assign in_mode     = s_tuser[0];
    assign in_new_path = s_tuser[1];
    assign in_wx       = s_tdata[31:0];
    assign in_wy       = s_tdata[63:32];
    assign in_px       = s_tdata[95:64];
    assign in_py       = s_tdata[127:96];
    assign in_heading  = s_tdata[143:128];

    // ------------------------------------------------------------------
    // Path state
    // ------------------------------------------------------------------
    logic [CW-1:0]     count_reg, pos_reg;
    wttd_pkg::motion_t motion_reg;

    // output register
    logic        m_tvalid_reg;
    logic [30:0] out_speed_reg;
    logic [15:0] out_turn_reg;
    logic [1:0]  out_mode_reg;
    logic [6:0]  out_wp_reg;
    logic        out_drop_reg;

    logic slot_free;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;

    logic accept;
    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Waypoint table: x in the upper half, y in the lower half
    // ------------------------------------------------------------------
    logic [63:0]   path_mem [PATH_DEPTH];
    logic [63:0]   rd_data_reg;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic          table_full;

    assign table_full  = !(count_reg < CW'(PATH_DEPTH));
    assign mem_wr_en   = accept && !in_mode && (in_new_path || !table_full);
    assign mem_wr_addr = in_new_path ? '0 : count_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            path_mem[mem_wr_addr] <= {in_wx, in_wy};
        end
        rd_data_reg <= path_mem[pos_reg[AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Tick operands and CORDIC set-up
    // ------------------------------------------------------------------
    logic [31:0] px_reg, py_reg;
    logic [15:0] heading_reg;
    logic        tick_ok;

    assign tick_ok = (count_reg != '0) && (pos_reg < count_reg) &&
                     (motion_reg == wttd_pkg::MS_TURN || motion_reg == wttd_pkg::MS_DRIVE);

    logic signed [32:0] dx, dy;
    logic signed [XW-1:0] cx_in, cy_in;
    logic        [31:0]   cz_in;

    always_comb begin
        dx = $signed({rd_data_reg[63], rd_data_reg[63:32]}) - $signed({px_reg[31], px_reg});
        dy = $signed({rd_data_reg[31], rd_data_reg[31:0]}) - $signed({py_reg[31], py_reg});
        // fold the left half-plane onto the right, angle offset by pi
        if (dx < 0) begin
            cx_in = -XW'(dx);
            cy_in = -XW'(dy);
            cz_in = 32'h80000000;
        end else begin
            cx_in = XW'(dx);
            cy_in = XW'(dy);
            cz_in = 32'h0;
        end
    end

    wttd_pkg::cordic_stat_t cstat;
    logic signed [XW-1:0]   cx_out;
    logic        [31:0]     cz_out;
    logic                   cordic_start;

    assign cordic_start = (state_reg == S_READ);

    wttd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (cx_in),
        .y_in    (cy_in),
        .z_in    (cz_in),
        .stat    (cstat),
        .x_out   (cx_out),
        .z_out   (cz_out)
    );

    // ------------------------------------------------------------------
    // Gain compensation and heading error
    // ------------------------------------------------------------------
    logic [DW-1:0] x_clamp;
    logic [PW-1:0] gain_prod;
    logic [31:0]   z_round;
    logic [DW-1:0] dist_reg;
    logic [15:0]   err_reg;

    always_comb begin
        x_clamp   = cx_out[XW-1] ? '0 : cx_out[DW-1:0];
        gain_prod = PW'(x_clamp) * PW'(wttd_pkg::GAIN_Q24) + PW'(32'h00800000);
        z_round   = cz_out + 32'h00008000;
    end

    // ------------------------------------------------------------------
    // Turn rate, speed and motion update
    // ------------------------------------------------------------------
    logic [16:0]       err_neg;
    logic [15:0]       err_mag;
    logic [31:0]       rate_prod;
    logic [14:0]       rate, rate_cl;
    logic [15:0]       turn_cmd;
    logic [DW-2:0]     spd_half, spd_cl;
    logic              arrived;
    logic [CW-1:0]     pos_inc;
    logic [CW-1:0]     pos_new;
    wttd_pkg::motion_t motion_new;
    logic [30:0]       spd_cmd;

    always_comb begin
        err_neg   = -{err_reg[15], err_reg};
        err_mag   = err_reg[15] ? err_neg[15:0] : err_reg;
        rate_prod = 32'(err_mag) * 32'(wttd_pkg::BAM_TO_RATE) + 32'h00008000;
        rate      = rate_prod[30:16];
        rate_cl   = (rate > max_turn_reg) ? max_turn_reg : rate;
        turn_cmd  = err_reg[15] ? -{1'b0, rate_cl} : {1'b0, rate_cl};
        spd_half  = dist_reg[DW-1:1];
        spd_cl    = (spd_half > (DW-1)'(max_speed_reg)) ? (DW-1)'(max_speed_reg) : spd_half;
        arrived   = dist_reg < DW'(arrival_reg);
        pos_inc   = pos_reg + 1'b1;
        pos_new   = pos_reg;
        motion_new = motion_reg;
        spd_cmd   = 31'd0;
        if (motion_reg == wttd_pkg::MS_TURN) begin
            if ({1'b0, err_mag} < {2'b0, head_tol_reg}) begin
                motion_new = wttd_pkg::MS_DRIVE;
            end
        end else begin
            spd_cmd = spd_cl[30:0];
            if (arrived) begin
                pos_new    = pos_inc;
                motion_new = (pos_inc < count_reg) ? wttd_pkg::MS_TURN : wttd_pkg::MS_IDLE;
            end
        end
    end

    // low 7 bits of an index of any width
    function automatic logic [6:0] wp_field(input logic [CW-1:0] p);
        logic [CW+6:0] ext;
        ext = {7'b0, p};
        return ext[6:0];
    endfunction

    // ------------------------------------------------------------------
    // Output valid: load on an answered beat, drop once taken
    // ------------------------------------------------------------------
    logic out_load;
    assign out_load = ((state_reg == S_IDLE) && accept && (!in_mode || !tick_ok)) ||
                      ((state_reg == S_POST) && slot_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            motion_reg   <= wttd_pkg::MS_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (!in_mode) begin
                            // load beat: answer at once
                            out_speed_reg <= '0;
                            out_turn_reg  <= '0;
                            out_drop_reg  <= 1'b0;
                            if (in_new_path) begin
                                count_reg    <= CW'(1);
                                pos_reg      <= '0;
                                motion_reg   <= wttd_pkg::MS_TURN;
                                out_mode_reg <= wttd_pkg::MS_TURN;
                                out_wp_reg   <= '0;
                            end else begin
                                if (!table_full) begin
                                    count_reg <= count_reg + 1'b1;
                                end else begin
                                    out_drop_reg <= 1'b1;
                                end
                                out_mode_reg <= motion_reg;
                                out_wp_reg   <= wp_field(pos_reg);
                            end
                        end else if (!tick_ok) begin
                            // nothing to steer toward: go idle, zero commands
                            motion_reg    <= wttd_pkg::MS_IDLE;
                            out_speed_reg <= '0;
                            out_turn_reg  <= '0;
                            out_drop_reg  <= 1'b0;
                            out_mode_reg  <= wttd_pkg::MS_IDLE;
                            out_wp_reg    <= wp_field(pos_reg);
                        end else begin
                            px_reg      <= in_px;
                            py_reg      <= in_py;
                            heading_reg <= in_heading;
                            state_reg   <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // table word is in rd_data_reg; CORDIC loads this cycle
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (cstat.done) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    dist_reg  <= gain_prod[PW-1:24];
                    err_reg   <= z_round[31:16] - heading_reg;
                    state_reg <= S_POST;
                end
                S_POST: begin
                    // hold until the output register can take the beat
                    if (slot_free) begin
                        out_speed_reg <= spd_cmd;
                        out_turn_reg  <= turn_cmd;
                        out_drop_reg  <= 1'b0;
                        out_mode_reg  <= motion_new;
                        out_wp_reg    <= wp_field(pos_new);
                        motion_reg    <= motion_new;
                        pos_reg       <= pos_new;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_wp_reg, out_mode_reg, out_turn_reg, out_speed_reg};
    assign m_tuser  = out_drop_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_in_path: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= count_reg)
        else $error("waypoint index ran past the stored path");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(PATH_DEPTH))
        else $error("waypoint count exceeds table depth");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cstat.done |-> state_reg == S_CORDIC)
        else $error("CORDIC finished outside its wait state");

    a_accept_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_tvalid_reg || state_reg == S_READ))
        else $error("accepted beat neither answered nor started");

endmodule

`default_nettype wire

### verif/tb_waypoint_turn_then_drive_controller.sv
// ----------------------------------------------------------------------------
// tb_waypoint_turn_then_drive_controller: self-checking bench for the
// turn-then-drive waypoint follower
// Walks a short table of directed beats, then random path episodes under
// several register settings, with random idling on both streams. Each result
// beat is checked against an in-bench model of the follower or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waypoint_turn_then_drive_controller;

    timeunit 1ns;
    timeprecision 1ps;

    import wttd_pkg::*;

    localparam int PATH_LEN     = PATH_DEPTH_DEF;
    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int PHASE_BEATS  = 170;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = STEPS + 12;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(REG_ARRIVAL_RADIUS + 1);

    // arctan(2^-k), 2^32 = 2 pi
    localparam logic [31:0] ARCTAN_LUT [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic               mode;
        logic               new_path;
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] heading;
    } path_beat_t;

    typedef struct packed {
        logic [30:0] speed;
        logic [15:0] turn;
        logic [1:0]  mode;
        logic [6:0]  wp;
        logic        dropped;
    } command_t;

    typedef struct {
        path_beat_t beat;
        bit         typed;
        command_t   want;
    } directed_row_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    waypoint_turn_then_drive_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Follower model: path table, index, motion state and registers
    // ------------------------------------------------------------------
    logic signed [31:0] path_x [PATH_LEN];
    logic signed [31:0] path_y [PATH_LEN];
    int unsigned        path_count = 0;
    int unsigned        path_index = 0;
    motion_t            motion     = MS_IDLE;
    logic [14:0]        turn_limit = MAX_TURN_RST;
    logic [30:0]        speed_limit = MAX_SPEED_RST;
    logic [14:0]        aim_tolerance = HEAD_TOL_RST;
    logic [30:0]        reach_radius  = ARRIVAL_RST;

    command_t command_q[$];       // commands still owed by the DUT
    int       mismatches  = 0;
    int       idle_pct    = 22;   // idling chance in percent, both streams
    int       beats_sent  = 0;
    int       cycle_count = 0;

    // Vectoring CORDIC: bearing in 16-bit binary angle, gain-compensated length
    function automatic void steer_vector(input longint dx, input longint dy,
                                         output logic [15:0] bearing,
                                         output longint unsigned span);
        longint      x, y, nx;
        logic [31:0] z, zr;
        x = dx;
        y = dy;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int k = 0; k < STEPS; k++) begin
            if (y > 0) begin
                nx = x + (y >>> k);
                y  = y - (x >>> k);
                z  = z + ARCTAN_LUT[k];
            end else begin
                nx = x - (y >>> k);
                y  = y + (x >>> k);
                z  = z - ARCTAN_LUT[k];
            end
            x = nx;
        end
        if (x < 0) x = 0;
        span    = (longint'(unsigned'(x)) * 64'd10188014 + 64'd8388608) >> 24;
        zr      = z + 32'h0000_8000;
        bearing = zr[31:16];
    endfunction

    // Advance the model by one accepted beat and return the command it owes
    function automatic command_t follow_step(input path_beat_t b);
        command_t        c;
        logic [15:0]     bearing, diff;
        longint unsigned span, spd;
        int              err;
        int unsigned     mag, rate;
        c = '0;
        if (!b.mode) begin
            if (b.new_path) begin
                path_x[0]  = b.wx;
                path_y[0]  = b.wy;
                path_count = 1;
                path_index = 0;
                motion     = MS_TURN;
            end else if (path_count < PATH_LEN) begin
                path_x[path_count] = b.wx;
                path_y[path_count] = b.wy;
                path_count++;
            end else begin
                c.dropped = 1'b1;
            end
            c.mode = motion;
            c.wp   = path_index[6:0];
            return c;
        end
        if (path_count == 0 || path_index >= path_count) motion = MS_IDLE;
        if (motion != MS_TURN && motion != MS_DRIVE) begin
            motion = MS_IDLE;
            c.mode = motion;
            c.wp   = path_index[6:0];
            return c;
        end
        steer_vector(longint'(path_x[path_index]) - longint'(b.px),
                     longint'(path_y[path_index]) - longint'(b.py), bearing, span);
        diff = bearing - b.heading;
        err  = int'($signed(diff));
        mag  = (err < 0) ? -err : err;
        rate = (mag * 32'd25736 + 32'h8000) >> 16;
        if (rate > turn_limit) rate = turn_limit;
        c.turn = (err < 0) ? -rate[15:0] : rate[15:0];
        spd = 0;
        if (motion == MS_TURN) begin
            if (mag < aim_tolerance) motion = MS_DRIVE;
        end else begin
            spd = span >> 1;
            if (spd > speed_limit) spd = speed_limit;
            if (span < reach_radius) begin
                path_index++;
                motion = (path_index < path_count) ? MS_TURN : MS_IDLE;
            end
        end
        c.speed = spd[30:0];
        c.mode  = motion;
        c.wp    = path_index[6:0];
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Input stream driver
    // ------------------------------------------------------------------
    task automatic send_beat(input path_beat_t b, input bit typed, input command_t want);
        command_t owed;
        // random gap before the beat; drop valid only while idling
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.heading, b.py, b.px, b.wy, b.wx};
        s_tuser  <= {b.new_path, b.mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        owed = follow_step(b);
        command_q.push_back(typed ? want : owed);
        beats_sent++;
    endtask

    // Hold off the sender until every owed command has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (command_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // One register write; the caller drops cfg_valid after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MAX_TURN_RATE:     turn_limit    = val[14:0];
            REG_MAX_SPEED:         speed_limit   = val[30:0];
            REG_HEADING_TOLERANCE: aim_tolerance = val[14:0];
            REG_ARRIVAL_RADIUS:    reach_radius  = val[30:0];
            default: ;
        endcase
    endtask

    // Program all four registers with junk above each field, plus one
    // write to an unused index that must change nothing
    task automatic program_regs(input logic [14:0] tr, input logic [30:0] sp,
                                input logic [14:0] tol, input logic [30:0] arr);
        write_reg(REG_MAX_TURN_RATE,     ($urandom() & 32'hFFFF_8000) | tr);
        write_reg(CFG_IDX_W'(FIRST_UNUSED_REG + $urandom_range(0, 251)), $urandom());
        write_reg(REG_MAX_SPEED,         ($urandom() & 32'h8000_0000) | sp);
        write_reg(REG_HEADING_TOLERANCE, ($urandom() & 32'hFFFF_8000) | tol);
        write_reg(REG_ARRIVAL_RADIUS,    ($urandom() & 32'h8000_0000) | arr);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random beat builders
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return int'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
        endcase
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Everything but the mode random: toggles every bit of every other field
    function automatic path_beat_t noise_beat(input logic mode);
        path_beat_t b;
        b.mode     = mode;
        b.new_path = 1'($urandom_range(0, 1));
        b.wx       = $urandom();
        b.wy       = $urandom();
        b.px       = $urandom();
        b.py       = $urandom();
        b.heading  = 16'($urandom());
        return b;
    endfunction

    function automatic path_beat_t load_beat(input logic fresh);
        path_beat_t b;
        b          = noise_beat(1'b0);
        b.new_path = fresh;
        b.wx       = pick_coord();
        b.wy       = pick_coord();
        return b;
    endfunction

    // Tick placed near the current waypoint with a heading close to the
    // bearing, so turning, driving and arrival are all reached
    function automatic path_beat_t aimed_tick();
        path_beat_t      b;
        logic [15:0]     bearing;
        longint unsigned span;
        b = noise_beat(1'b1);
        if (path_index >= path_count) return b;
        case ($urandom_range(0, 9))
            0, 1, 2:    begin b.px = path_x[path_index] - spread(400);
                              b.py = path_y[path_index] - spread(400); end
            3, 4, 5, 6: begin b.px = path_x[path_index] - spread(1 << 20);
                              b.py = path_y[path_index] - spread(1 << 20); end
            7, 8:       begin b.px = path_x[path_index] - spread(1 << 26);
                              b.py = path_y[path_index] - spread(1 << 26); end
            default: ;
        endcase
        steer_vector(longint'(path_x[path_index]) - longint'(b.px),
                     longint'(path_y[path_index]) - longint'(b.py), bearing, span);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: b.heading = 16'(bearing + spread(200));
            5, 6:          b.heading = 16'(bearing + spread(3000));
            7:             b.heading = bearing + 16'h8000;  // error of exactly -pi
            default: ;
        endcase
        return b;
    endfunction

    // One path episode: fresh path, some appends, ticks until the path is done
    task automatic run_path(input int appends);
        int guard;
        int roll;
        send_beat(load_beat(1'b1), 1'b0, '0);
        for (int n = 0; n < appends; n++) begin
            if ($urandom_range(0, 4) == 0) send_beat(aimed_tick(), 1'b0, '0);
            send_beat(load_beat(1'b0), 1'b0, '0);
        end
        guard = 12 + 8 * ((appends > 8) ? 9 : appends + 1);
        while (guard > 0 && motion != MS_IDLE) begin
            roll = $urandom_range(0, 99);
            if (roll < 86)      send_beat(aimed_tick(), 1'b0, '0);
            else if (roll < 93) send_beat(noise_beat(1'b1), 1'b0, '0);
            else if (roll < 98) send_beat(load_beat(1'b0), 1'b0, '0);
            else                send_beat(load_beat(1'b1), 1'b0, '0);
            guard--;
        end
        // idle tail: a tick, and sometimes an append while idle
        send_beat(aimed_tick(), 1'b0, '0);
        if ($urandom_range(0, 2) == 0) send_beat(load_beat(1'b0), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result stream: random stalls and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        command_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
            if (m_tvalid && m_tready) begin
                got.speed   = m_tdata[30:0];
                got.turn    = m_tdata[46:31];
                got.mode    = m_tdata[48:47];
                got.wp      = m_tdata[55:49];
                got.dropped = m_tuser[0];
                if (command_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: spd=%0d turn=%0d mode=%0d wp=%0d drop=%0d",
                                 got.speed, $signed(got.turn), got.mode, got.wp, got.dropped);
                end else begin
                    want = command_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch: expected spd=%0d turn=%0d mode=%0d ",
                                      "wp=%0d drop=%0d, got spd=%0d turn=%0d mode=%0d ",
                                      "wp=%0d drop=%0d"},
                                     want.speed, $signed(want.turn), want.mode, want.wp,
                                     want.dropped, got.speed, $signed(got.turn), got.mode,
                                     got.wp, got.dropped);
                    end
                end
            end
        end
    end

    // Watchdog: a stuck handshake ends the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    directed_row_t directed_rows[$];

    function automatic command_t cmd(input motion_t m, input int wp, input logic drop);
        command_t c;
        c         = '0;
        c.mode    = m;
        c.wp      = wp[6:0];
        c.dropped = drop;
        return c;
    endfunction

    task automatic add_row(input logic mode, input logic fresh,
                           input logic [31:0] wx, input logic [31:0] wy,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] hd, input bit typed, input command_t want);
        directed_row_t r;
        r.beat  = '{mode: mode, new_path: fresh, wx: wx, wy: wy, px: px, py: py, heading: hd};
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic mode_load, mode_tick;
        mode_load = 1'b0;
        mode_tick = 1'b1;

        // tick with an empty path right after reset
        add_row(mode_tick, 0, 0, 0, 0, 0, 0, 1, cmd(MS_IDLE, 0, 0));
        // append while idle: stored, still idle
        add_row(mode_load, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1, cmd(MS_IDLE, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'h7FFF, 1, cmd(MS_IDLE, 0, 0));
        // fresh path at the origin, robot on top of it: zero vector; the
        // CORDIC still rotates its angle down to 0xB8F9, so aim the heading there
        add_row(mode_load, 1, 0, 0, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'hB8F9, 1, cmd(MS_DRIVE, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'hB8F9, 1, cmd(MS_IDLE, 1, 0));
        // index past the end
        add_row(mode_tick, 0, 0, 0, 0, 0, 0, 1, cmd(MS_IDLE, 1, 0));
        // coordinate extremes, largest possible vectors
        add_row(mode_load, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_load, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_tick, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 16'h7FFF, 0, '0);
        add_row(mode_tick, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 0, '0);
        // one meter east: heading at -pi, at +pi, then aligned, drive, arrive
        add_row(mode_load, 1, 32'h0001_0000, 0, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'h8000, 0, '0);
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'h7FFF, 0, '0);
        add_row(mode_tick, 0, 0, 0, 0, 0, 0, 0, '0);
        add_row(mode_tick, 0, 0, 0, 0, 0, 0, 0, '0);
        add_row(mode_tick, 0, 0, 0, 32'h0001_0000, 32'h0000_0100, 0, 0, '0);
        // append after the path finished: stays idle
        add_row(mode_load, 0, 32'h0002_0000, 0, 0, 0, 0, 1, cmd(MS_IDLE, 1, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 0, 1, cmd(MS_IDLE, 1, 0));
        // waypoint behind the robot (negative x)
        add_row(mode_load, 1, 32'hFFFF_0000, 32'h0000_0100, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'h7FFF, 0, '0);
        // straight south
        add_row(mode_load, 1, 0, 32'hFFFE_0000, 0, 0, 0, 1, cmd(MS_TURN, 0, 0));
        add_row(mode_tick, 0, 0, 0, 0, 0, 16'hC000, 0, '0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Random episodes under five register settings; each phase starts
        // with the sender held off until all owed commands have come back
        for (int phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                0: program_regs(MAX_TURN_RST, MAX_SPEED_RST, HEAD_TOL_RST, ARRIVAL_RST);
                1: program_regs(15'h7FFF, 31'h7FFF_FFFF, 15'h7FFF, 31'h7FFF_FFFF);
                2: program_regs('0, '0, '0, '0);
                3: program_regs(15'($urandom_range(0, 32767)),
                                31'($urandom_range(0, 32'h0010_0000)),
                                15'($urandom_range(100, 4000)),
                                31'($urandom_range(500, 100000)));
                default: program_regs(15'($urandom()), 31'($urandom()),
                                      15'($urandom_range(0, 32767)),
                                      31'($urandom_range(0, 32'h0004_0000)));
            endcase
            // phase one runs with no idling at all on either stream
            idle_pct = (phase == 1) ? 0 : 22;
            beats_sent = 0;
            // open with a full table so loads get dropped
            if (phase == 0) run_path(PATH_LEN + 2);
            while (beats_sent < PHASE_BEATS)
                run_path(($urandom_range(0, 24) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 4));
        end

        drain_results();
        if (mismatches == 0 && command_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
